// ===== rtl/mfw_pkg.sv =====
package mfw_pkg;

    localparam int OFF_W     = 16;
    localparam int COEF_W    = 16;
    localparam int WGT_W     = 18;
    localparam int CFG_IDX_W = 2;
    localparam int NUM_AXES  = 2;

    // magnitude bits that matter once |t| >= 2.0 is flagged
    localparam int A_W = 14;
    // polynomial coefficient width (scaled by 2^15)
    localparam int K_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_COEF_B = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_COEF_C = CFG_IDX_W'(1);

    localparam logic [COEF_W-1:0] COEF_RESET = COEF_W'(10923);
    localparam logic [COEF_W:0]   ONE_Q15    = (COEF_W+1)'(32768);

    // Q3.13 thresholds on |offset|
    localparam logic [OFF_W:0] ONE_T = (OFF_W+1)'(8192);
    localparam logic [OFF_W:0] TWO_T = (OFF_W+1)'(16384);

    localparam logic signed [K_W-1:0] NEAR_K3 = K_W'(393216);
    localparam logic signed [K_W-1:0] NEAR_K2 = K_W'(-589824);
    localparam logic signed [K_W-1:0] NEAR_K0 = K_W'(196608);

    typedef struct packed {
        logic signed [K_W-1:0] k3;
        logic signed [K_W-1:0] k2;
        logic signed [K_W-1:0] k1;
        logic signed [K_W-1:0] k0;
    } coef_set_t;

    // 6*w(t) for t <= 1, coefficients in Q15
    function automatic coef_set_t near_coefs(input logic [COEF_W:0] b,
                                             input logic [COEF_W:0] c);
        logic signed [K_W-1:0] bs;
        logic signed [K_W-1:0] cs;
        coef_set_t             k;
        bs   = signed'(K_W'(b));
        cs   = signed'(K_W'(c));
        k.k3 = NEAR_K3 - ((bs <<< 3) + bs) - ((cs <<< 2) + (cs <<< 1));
        k.k2 = NEAR_K2 + ((bs <<< 3) + (bs <<< 2)) + ((cs <<< 2) + (cs <<< 1));
        k.k1 = '0;
        k.k0 = NEAR_K0 - (bs <<< 1);
        return k;
    endfunction

    // 6*w(t) for 1 < t < 2
    function automatic coef_set_t far_coefs(input logic [COEF_W:0] b,
                                            input logic [COEF_W:0] c);
        logic signed [K_W-1:0] bs;
        logic signed [K_W-1:0] cs;
        coef_set_t             k;
        bs   = signed'(K_W'(b));
        cs   = signed'(K_W'(c));
        k.k3 = -bs - ((cs <<< 2) + (cs <<< 1));
        k.k2 = ((bs <<< 2) + (bs <<< 1)) + ((cs <<< 5) - (cs <<< 1));
        k.k1 = -((bs <<< 3) + (bs <<< 2)) - ((cs <<< 5) + (cs <<< 4));
        k.k0 = (bs <<< 3) + ((cs <<< 4) + (cs <<< 3));
        return k;
    endfunction

endpackage

// ===== rtl/mitchell_filter_weight_top.sv =====
// channel | signals                                  | direction | transfer when
// --------+------------------------------------------+-----------+----------------------
// cfg     | cfg_valid cfg_ready cfg_index cfg_data   | in        | cfg_valid & cfg_ready
// in      | in_valid in_ready sample_dx sample_dy    | in        | in_valid & in_ready
// out     | out_valid out_ready filter_weight        | out       | out_valid & out_ready
//
// One item per cycle sustained while out is not stalled; the result passes the s1..s8 and fw_reg registers.
// Depth is set by the Horner evaluation: three multiply-accumulate steps by |t|, the two
// wide ones split into partial products, then a divide by 6 and the x*y product.
// Reset (rst_n, async low) clears the valid pipe and loads B = C = 10923; cfg always ready.
// When out is stalled the whole pipe holds; in_ready drops only while the output is full.
module mitchell_filter_weight_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [mfw_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [mfw_pkg::COEF_W-1:0]          cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [mfw_pkg::OFF_W-1:0]    sample_dx,
    input  logic signed [mfw_pkg::OFF_W-1:0]    sample_dy,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [mfw_pkg::WGT_W-1:0]    filter_weight
);

    localparam int LN    = mfw_pkg::NUM_AXES;
    localparam int OW    = mfw_pkg::OFF_W;
    localparam int CW    = mfw_pkg::COEF_W;
    localparam int AW    = mfw_pkg::A_W;
    localparam int KW    = mfw_pkg::K_W;
    localparam int WW    = mfw_pkg::WGT_W;
    localparam int NSTG  = 8;
    localparam int H1W   = 37;
    localparam int H1_LO = 19;
    localparam int PLW   = H1_LO + AW + 2;
    localparam int PHW   = (H1W - H1_LO) + AW + 1;
    localparam int H2W   = 52;
    localparam int H2_LO = 26;
    localparam int QLW   = H2_LO + AW + 2;
    localparam int QHW   = (H2W - H2_LO) + AW + 1;
    localparam int H3W   = 64;
    localparam int XW    = 32;
    localparam int ZW    = 31;
    localparam int QW    = 30;
    localparam int PW    = 2 * QW;
    localparam int RW    = PW - 32;

    // p + 3*2^30 so the later floor gives round-half-up
    localparam logic signed [H3W-1:0] P_RND  = H3W'(64'h0000_0000_C000_0000);
    // floor(x/6) = floor((floor(x/2) + 3*2^28) / 3) - 2^28
    localparam logic signed [XW-1:0]  X_BIAS = XW'(32'h3000_0000);
    localparam logic [31:0]           RECIP3 = 32'hAAAA_AAAB;
    localparam logic [QW-1:0]         Q_BIAS = QW'(32'h1000_0000);
    localparam logic signed [PW-1:0]  W_RND  = PW'(64'h0000_0000_8000_0000);
    localparam logic signed [RW-1:0]  R_MAX  = RW'(131071);
    localparam logic signed [RW-1:0]  R_MIN  = RW'(-131072);

    // ---------------- configuration ----------------
    logic [CW-1:0] coef_b_reg;
    logic [CW-1:0] coef_c_reg;
    logic [CW:0]   b_sat;
    logic [CW:0]   c_sat;
    mfw_pkg::coef_set_t near_k;
    mfw_pkg::coef_set_t far_k;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_b_reg <= mfw_pkg::COEF_RESET;
            coef_c_reg <= mfw_pkg::COEF_RESET;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == mfw_pkg::REG_COEF_B)
                coef_b_reg <= cfg_data;
            if (cfg_index == mfw_pkg::REG_COEF_C)
                coef_c_reg <= cfg_data;
        end
    end

    assign b_sat  = ({1'b0, coef_b_reg} > mfw_pkg::ONE_Q15) ? mfw_pkg::ONE_Q15
                                                            : {1'b0, coef_b_reg};
    assign c_sat  = ({1'b0, coef_c_reg} > mfw_pkg::ONE_Q15) ? mfw_pkg::ONE_Q15
                                                            : {1'b0, coef_c_reg};
    assign near_k = mfw_pkg::near_coefs(b_sat, c_sat);
    assign far_k  = mfw_pkg::far_coefs(b_sat, c_sat);

    // ---------------- flow control ----------------
    logic            en;
    logic [NSTG-1:0] vld_reg;
    logic            out_valid_reg;

    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg       <= {vld_reg[NSTG-2:0], in_valid};
            out_valid_reg <= vld_reg[NSTG-1];
        end
    end

    // ---------------- datapath, one lane per axis ----------------
    logic signed [OW-1:0] off_in [LN];
    logic [OW:0]          mag    [LN];

    logic [AW-1:0]        s1_a_next    [LN];
    logic                 s1_zero_next [LN];
    mfw_pkg::coef_set_t   s1_k_next    [LN];
    logic [AW-1:0]        s1_a_reg     [LN];
    logic                 s1_zero_reg  [LN];
    mfw_pkg::coef_set_t   s1_k_reg     [LN];

    logic signed [AW:0]     s1_as   [LN];
    logic signed [KW+AW:0]  m2      [LN];
    logic signed [H1W-1:0]  s2_h1_next  [LN];
    logic signed [H1W-1:0]  s2_h1_reg   [LN];
    logic [AW-1:0]          s2_a_reg    [LN];
    logic                   s2_zero_reg [LN];
    mfw_pkg::coef_set_t     s2_k_reg    [LN];

    logic signed [AW:0]     s2_as       [LN];
    logic signed [PLW-1:0]  s3_pl_next  [LN];
    logic signed [PHW-1:0]  s3_ph_next  [LN];
    logic signed [PLW-1:0]  s3_pl_reg   [LN];
    logic signed [PHW-1:0]  s3_ph_reg   [LN];
    logic [AW-1:0]          s3_a_reg    [LN];
    logic                   s3_zero_reg [LN];
    mfw_pkg::coef_set_t     s3_k_reg    [LN];

    logic signed [H2W-1:0]  s4_h2_next  [LN];
    logic signed [H2W-1:0]  s4_h2_reg   [LN];
    logic [AW-1:0]          s4_a_reg    [LN];
    logic                   s4_zero_reg [LN];
    mfw_pkg::coef_set_t     s4_k_reg    [LN];

    logic signed [AW:0]     s4_as       [LN];
    logic signed [QLW-1:0]  s5_ql_next  [LN];
    logic signed [QHW-1:0]  s5_qh_next  [LN];
    logic signed [QLW-1:0]  s5_ql_reg   [LN];
    logic signed [QHW-1:0]  s5_qh_reg   [LN];
    logic                   s5_zero_reg [LN];
    mfw_pkg::coef_set_t     s5_k_reg    [LN];

    logic signed [H3W-1:0]  h3          [LN];
    logic signed [XW-1:0]   s6_x_next   [LN];
    logic signed [XW-1:0]   s6_x_reg    [LN];
    logic                   s6_zero_reg [LN];

    logic signed [XW-1:0]   x_half      [LN];
    logic [ZW-1:0]          z7          [LN];
    logic [ZW+31:0]         recip_prod  [LN];
    logic [QW-1:0]          s7_q_next   [LN];
    logic [QW-1:0]          s7_q_reg    [LN];
    logic                   s7_zero_reg [LN];

    logic signed [QW-1:0]   w8          [LN];
    logic signed [PW-1:0]   s8_prod_next;
    logic signed [PW-1:0]   s8_prod_reg;

    logic signed [PW-1:0]   prod_rnd;
    logic signed [RW-1:0]   r9;
    logic signed [WW-1:0]   fw_next;
    logic signed [WW-1:0]   fw_reg;

    assign off_in[0] = sample_dx;
    assign off_in[1] = sample_dy;

    always_comb
    begin
        for (int i = 0; i < LN; i++)
        begin
            // stage 1: |t|, range flags, pick cubic
            mag[i]          = off_in[i][OW-1] ? (~{off_in[i][OW-1], off_in[i]} + (OW+1)'(1))
                                              : {off_in[i][OW-1], off_in[i]};
            s1_a_next[i]    = mag[i][AW-1:0];
            s1_zero_next[i] = (mag[i] >= mfw_pkg::TWO_T);
            s1_k_next[i]    = (mag[i] > mfw_pkg::ONE_T) ? far_k : near_k;

            // stage 2: h1 = k3*a + k2*2^13
            s1_as[i]      = signed'({1'b0, s1_a_reg[i]});
            m2[i]         = s1_k_reg[i].k3 * s1_as[i];
            s2_h1_next[i] = H1W'(m2[i]) + (H1W'(s1_k_reg[i].k2) <<< 13);

            // stage 3: h1*a as two partial products
            s2_as[i]      = signed'({1'b0, s2_a_reg[i]});
            s3_pl_next[i] = signed'({1'b0, s2_h1_reg[i][H1_LO-1:0]}) * s2_as[i];
            s3_ph_next[i] = signed'(s2_h1_reg[i][H1W-1:H1_LO]) * s2_as[i];

            // stage 4: h2 = h1*a + k1*2^26
            s4_h2_next[i] = (H2W'(s3_ph_reg[i]) <<< H1_LO) + H2W'(s3_pl_reg[i])
                          + (H2W'(s3_k_reg[i].k1) <<< 26);

            // stage 5: h2*a as two partial products
            s4_as[i]      = signed'({1'b0, s4_a_reg[i]});
            s5_ql_next[i] = signed'({1'b0, s4_h2_reg[i][H2_LO-1:0]}) * s4_as[i];
            s5_qh_next[i] = signed'(s4_h2_reg[i][H2W-1:H2_LO]) * s4_as[i];

            // stage 6: p = h2*a + k0*2^39, plus rounding, then floor by 2^30
            h3[i]        = (H3W'(s5_qh_reg[i]) <<< H2_LO) + H3W'(s5_ql_reg[i])
                         + (H3W'(s5_k_reg[i].k0) <<< 39) + P_RND;
            s6_x_next[i] = signed'(h3[i][XW+29:30]);

            // stage 7: floor divide by 6 via reciprocal of 3 on a biased value
            x_half[i]     = (s6_x_reg[i] >>> 1) + X_BIAS;
            z7[i]         = x_half[i][ZW-1:0];
            recip_prod[i] = z7[i] * RECIP3;
            s7_q_next[i]  = recip_prod[i][ZW+31:33];

            // stage 8 operand: Q24 axis weight
            w8[i] = s7_zero_reg[i] ? '0 : signed'(s7_q_reg[i] - Q_BIAS);
        end

        s8_prod_next = w8[0] * w8[1];

        // stage 9: round Q48 to Q16 and saturate
        prod_rnd = s8_prod_reg + W_RND;
        r9       = prod_rnd[PW-1:32];
        if (r9 > R_MAX)
            fw_next = R_MAX[WW-1:0];
        else if (r9 < R_MIN)
            fw_next = R_MIN[WW-1:0];
        else
            fw_next = r9[WW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < LN; i++)
            begin
                s1_a_reg[i]    <= s1_a_next[i];
                s1_zero_reg[i] <= s1_zero_next[i];
                s1_k_reg[i]    <= s1_k_next[i];

                s2_h1_reg[i]   <= s2_h1_next[i];
                s2_a_reg[i]    <= s1_a_reg[i];
                s2_zero_reg[i] <= s1_zero_reg[i];
                s2_k_reg[i]    <= s1_k_reg[i];

                s3_pl_reg[i]   <= s3_pl_next[i];
                s3_ph_reg[i]   <= s3_ph_next[i];
                s3_a_reg[i]    <= s2_a_reg[i];
                s3_zero_reg[i] <= s2_zero_reg[i];
                s3_k_reg[i]    <= s2_k_reg[i];

                s4_h2_reg[i]   <= s4_h2_next[i];
                s4_a_reg[i]    <= s3_a_reg[i];
                s4_zero_reg[i] <= s3_zero_reg[i];
                s4_k_reg[i]    <= s3_k_reg[i];

                s5_ql_reg[i]   <= s5_ql_next[i];
                s5_qh_reg[i]   <= s5_qh_next[i];
                s5_zero_reg[i] <= s4_zero_reg[i];
                s5_k_reg[i]    <= s4_k_reg[i];

                s6_x_reg[i]    <= s6_x_next[i];
                s6_zero_reg[i] <= s5_zero_reg[i];

                s7_q_reg[i]    <= s7_q_next[i];
                s7_zero_reg[i] <= s6_zero_reg[i];
            end
            s8_prod_reg <= s8_prod_next;
            fw_reg      <= fw_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign filter_weight = fw_reg;

endmodule

// ===== sim/mitchell_filter_weight_top_test.sv =====
`timescale 1ns / 100ps

module mitchell_filter_weight_top_test;

    localparam int     CLK_HALF    = 6;
    localparam int     CYCLE_LIMIT = 200000;
    localparam int     PHASE_ITEMS = 75;
    localparam longint Q15_ONE     = 32768;
    localparam longint T_ONE       = 8192;
    localparam longint T_TWO       = 16384;
    localparam longint W_MAX       = 131071;
    localparam longint W_MIN       = -131072;

    typedef logic signed [mfw_pkg::OFF_W-1:0]  offset_t;
    typedef logic signed [mfw_pkg::WGT_W-1:0]  weight_t;
    typedef logic [mfw_pkg::COEF_W-1:0]        coef_t;
    typedef logic [mfw_pkg::CFG_IDX_W-1:0]     reg_index_t;

    // index with no register behind it; writes must be ignored
    localparam reg_index_t REG_UNMAPPED = reg_index_t'(3);

    typedef struct packed {
        offset_t x;
        offset_t y;
    } sample_offset_t;

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  cfg_valid     = 1'b0;
    logic                  cfg_ready;
    reg_index_t            cfg_index     = '0;
    coef_t                 cfg_data      = '0;
    logic                  in_valid      = 1'b0;
    logic                  in_ready;
    offset_t               sample_dx     = '0;
    offset_t               sample_dy     = '0;
    logic                  out_valid;
    logic                  out_ready     = 1'b0;
    weight_t               filter_weight;

    sample_offset_t        offset_pending_q[$];
    weight_t               weight_expected_q[$];

    coef_t                 coef_b_shadow = mfw_pkg::COEF_RESET;
    coef_t                 coef_c_shadow = mfw_pkg::COEF_RESET;
    int                    send_idle_pct = 0;
    int                    recv_stall_pct = 0;
    int                    mismatch_count = 0;
    int                    cycle_count    = 0;

    mitchell_filter_weight_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .sample_dx     (sample_dx),
        .sample_dy     (sample_dy),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .filter_weight (filter_weight)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    function automatic longint floor_div(input longint n, input longint d);
        if (n >= 0)
            return n / d;
        return -((-n + d - 1) / d);
    endfunction

    // one axis of the cubic, Q24; polynomial held exactly at 2^54 scale
    function automatic longint axis_weight_q24(input offset_t off,
                                               input coef_t b_reg,
                                               input coef_t c_reg);
        longint t;
        longint b;
        longint c;
        longint t2;
        longint t3;
        longint k3;
        longint k2;
        longint k1;
        longint k0;
        longint poly;
        t  = longint'(off);
        t  = (t < 0) ? -t : t;
        b  = longint'(b_reg);
        c  = longint'(c_reg);
        b  = (b > Q15_ONE) ? Q15_ONE : b;
        c  = (c > Q15_ONE) ? Q15_ONE : c;
        t2 = t * t;
        t3 = t2 * t;
        if (t >= T_TWO)
            return 0;
        if (t <= T_ONE)
        begin
            k3   = 12 * Q15_ONE - 9 * b - 6 * c;
            k2   = -18 * Q15_ONE + 12 * b + 6 * c;
            k0   = 6 * Q15_ONE - 2 * b;
            poly = k3 * t3 + (k2 * t2) * 8192 + k0 * (longint'(1) << 39);
        end
        else
        begin
            k3   = -b - 6 * c;
            k2   = 6 * b + 30 * c;
            k1   = -12 * b - 48 * c;
            k0   = 8 * b + 24 * c;
            poly = k3 * t3 + (k2 * t2) * 8192 + (k1 * t) * (longint'(1) << 26)
                   + k0 * (longint'(1) << 39);
        end
        return floor_div(poly + (longint'(3) << 30), longint'(6) << 30);
    endfunction

    function automatic weight_t filter_weight_of(input sample_offset_t s,
                                                 input coef_t b_reg,
                                                 input coef_t c_reg);
        longint prod;
        longint w;
        prod = axis_weight_q24(s.x, b_reg, c_reg) * axis_weight_q24(s.y, b_reg, c_reg);
        w    = (prod + (longint'(1) << 31)) >>> 32;
        if (w > W_MAX)
            w = W_MAX;
        if (w < W_MIN)
            w = W_MIN;
        return weight_t'(w);
    endfunction

    // driver: next offset pair goes out once the current one has transferred
    always @(posedge clk or negedge rst_n)
    begin
        sample_offset_t s;
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || in_ready)
        begin
            if (offset_pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                s          = offset_pending_q.pop_front();
                in_valid  <= 1'b1;
                sample_dx <= s.x;
                sample_dy <= s.y;
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // monitor: register shadow, expected weights, output check
    always @(posedge clk)
    begin
        weight_t        exp_w;
        sample_offset_t s_in;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    mfw_pkg::REG_COEF_B: coef_b_shadow <= cfg_data;
                    mfw_pkg::REG_COEF_C: coef_c_shadow <= cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
            begin
                s_in.x = sample_dx;
                s_in.y = sample_dy;
                weight_expected_q.push_back(filter_weight_of(s_in, coef_b_shadow,
                                                             coef_c_shadow));
            end
            if (out_valid && out_ready)
            begin
                if (weight_expected_q.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected weight transfer: got %0d", filter_weight);
                end
                else
                begin
                    exp_w = weight_expected_q.pop_front();
                    if (filter_weight !== exp_w)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("filter_weight mismatch: expected %0d, got %0d",
                                     exp_w, filter_weight);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic void push_offsets(input int x, input int y);
        sample_offset_t s;
        s.x = offset_t'(x);
        s.y = offset_t'(y);
        offset_pending_q.push_back(s);
    endfunction

    // mostly inside the support, some near the knots, some anywhere
    function automatic int rand_offset();
        int sel;
        sel = $urandom_range(9);
        case (sel)
            0, 1: return int'(offset_t'($urandom));
            2: return ($urandom_range(1) ? 1 : -1) * (8192 + $urandom_range(8) - 4);
            3: return ($urandom_range(1) ? 1 : -1) * (16384 + $urandom_range(8) - 4);
            default: return $urandom_range(32766) - 16383;
        endcase
    endfunction

    task automatic write_reg(input reg_index_t idx, input coef_t val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (offset_pending_q.size() != 0 || in_valid || weight_expected_q.size() != 0)
            @(negedge clk);
    endtask

    task automatic run_phase(input coef_t b, input coef_t c,
                             input int idle_pct, input int stall_pct);
        drain();
        write_reg(mfw_pkg::REG_COEF_B, b);
        write_reg(mfw_pkg::REG_COEF_C, c);
        @(negedge clk);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (PHASE_ITEMS)
            push_offsets(rand_offset(), rand_offset());
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset coefficients, knots and extremes of the offset range
        send_idle_pct  = 8;
        recv_stall_pct = 65;
        push_offsets(0, 0);
        push_offsets(8192, 0);
        push_offsets(-8192, 8192);
        push_offsets(8191, -8193);
        push_offsets(8193, 12288);
        push_offsets(16383, 0);
        push_offsets(-16383, -16383);
        push_offsets(16384, 0);
        push_offsets(0, -16384);
        push_offsets(16385, 100);
        push_offsets(-32768, 0);
        push_offsets(0, -32768);
        push_offsets(32767, 32767);
        push_offsets(-32768, -32768);
        push_offsets(1, -1);
        push_offsets(-12288, 4096);
        push_offsets(21845, -5461);
        push_offsets(-16385, 8192);
        push_offsets(10922, -10923);
        push_offsets(8192, 8192);

        run_phase(coef_t'(0), coef_t'(0), 8, 65);
        run_phase(coef_t'(32768), coef_t'(32768), 8, 65);
        run_phase(coef_t'(65535), coef_t'(65535), 65, 8);
        drain();
        write_reg(REG_UNMAPPED, coef_t'(0));
        run_phase(coef_t'(32769), coef_t'(0), 65, 8);
        run_phase(coef_t'($urandom_range(65535)), coef_t'($urandom_range(65535)), 0, 0);
        run_phase(coef_t'(0), coef_t'(32768), 0, 0);
        drain();

        repeat (12) @(posedge clk);
        if (mismatch_count == 0 && weight_expected_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
